### rtl/mma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Montgomery modular ALU package
// Shared word widths, operation codes, register indexes and the request and
// response bundles of the Montgomery multiplier.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned PLAIN_BITS   = 64;
  localparam int unsigned EXP_BITS     = 64;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [2*WORD_BITS-1:0] dword_t;

  typedef enum logic [2:0] {
    ACT_TO_MONT   = 3'd0,
    ACT_FROM_MONT = 3'd1,
    ACT_ADD       = 3'd2,
    ACT_SUB       = 3'd3,
    ACT_MUL       = 3'd4,
    ACT_DIV       = 3'd5,
    ACT_POW       = 3'd6,
    ACT_NEG       = 3'd7
  } action_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEG_INVERSE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_R_SQUARED   = 2'd2;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t p;
  } mul_rsp_t;

endpackage : mma_pkg
`default_nettype wire

### rtl/montgomery_modular_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Montgomery modular ALU
// One modular operation per request for an odd modulus below 2^32, R = 2^32.
// ----------------------------------------------------------------------------
// A request transfers on a rising edge with start high and busy low. Its one
// result appears on result for a single cycle with done high; the receiver
// must take it then. Configuration writes on cfg_valid/cfg_ready (ready is
// always high) set modulus, neg_inverse and r2_mod; the user must make them
// only while the block is idle, as the block itself does not enforce this.
// Add, subtract and negate need no multiply: done follows the transfer on
// the next edge and busy stays low. Every other operation runs on one shared
// Montgomery multiplier. Multiply and from_mont take one product; to_mont
// runs 64 remainder steps, a sign fix, then one multiply. Power takes an
// initial product, one squaring for each exponent bit below the highest set
// bit and one more product for each set bit. Division is a power by N-2 and
// one more multiply. Reset returns the registers to modulus 1, neg_inverse all
// ones and r2_mod 0, abandons any operation in flight and drops busy and done.
// ----------------------------------------------------------------------------
module montgomery_modular_alu
  import mma_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              action,
  input  wire logic [WORD_BITS-1:0]    operand_a,
  input  wire logic [WORD_BITS-1:0]    operand_b,
  input  wire logic [PLAIN_BITS-1:0]   plain_value,
  input  wire logic [EXP_BITS-1:0]     exponent,
  output logic [WORD_BITS-1:0]         result,
  output logic                         done,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [WORD_BITS-1:0]    cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOD  = 6'b000010,
    S_ONE  = 6'b000100,
    S_PMUL = 6'b001000,
    S_SQR  = 6'b010000,
    S_LAST = 6'b100000
  } seq_state_t;

  word_t         modulus;
  word_t         neg_inverse;
  word_t         r2_mod;

  seq_state_t    state;
  action_t       act;
  action_t       act_in;
  logic [EXP_BITS-1:0] e;
  word_t         acc;
  word_t         x;
  word_t         saved_a;

  mul_req_t      mul_req;
  mul_rsp_t      mul_rsp;
  logic          red_start;
  logic          red_done;
  word_t         red_res;

  logic [WORD_BITS:0]  add_sum;
  logic [WORD_BITS:0]  add_sub;
  word_t               simple_res;

  logic [EXP_BITS-1:0] d_e;
  word_t               d_acc;
  word_t               d_x;
  word_t               fin_val;
  logic                fin_now;

  assign cfg_ready = 1'b1;
  assign busy      = state != S_IDLE;
  assign act_in    = action_t'(action);
  assign red_start = start && !busy && (act_in == ACT_TO_MONT);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= WORD_BITS'(1);
      neg_inverse <= '1;
      r2_mod      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODULUS:     modulus     <= cfg_data;
        CFG_NEG_INVERSE: neg_inverse <= cfg_data;
        CFG_R_SQUARED:   r2_mod      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign add_sum = {1'b0, operand_a} + {1'b0, operand_b};
  assign add_sub = add_sum - {1'b0, modulus};

  always_comb begin
    case (act_in)
      ACT_ADD: begin
        simple_res = (add_sum[WORD_BITS] || add_sum[WORD_BITS-1:0] >= modulus)
                     ? add_sub[WORD_BITS-1:0] : add_sum[WORD_BITS-1:0];
      end
      ACT_SUB: begin
        simple_res = (operand_a < operand_b) ? (operand_a + modulus - operand_b)
                                             : (operand_a - operand_b);
      end
      default: begin
        simple_res = (operand_a == '0) ? '0 : (modulus - operand_a);
      end
    endcase
  end

  // Decision point of the square-and-multiply loop, after the initial one,
  // after each squaring and after each multiply.
  always_comb begin
    if (state == S_ONE) begin
      d_e   = e;
      d_acc = mul_rsp.p;
      d_x   = x;
    end else begin
      d_e   = e >> 1;
      d_acc = acc;
      d_x   = mul_rsp.p;
    end
    if (state == S_PMUL) begin
      fin_val = mul_rsp.p;
      fin_now = e[EXP_BITS-1:1] == '0;
    end else begin
      fin_val = d_acc;
      fin_now = d_e == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      mul_req.start <= 1'b0;
    end else begin
      done          <= 1'b0;
      mul_req.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            act <= act_in;
            case (act_in) inside
              ACT_ADD, ACT_SUB, ACT_NEG: begin
                result <= simple_res;
                done   <= 1'b1;
              end
              ACT_MUL: begin
                mul_req <= '{start: 1'b1, a: operand_a, b: operand_b};
                state   <= S_LAST;
              end
              ACT_FROM_MONT: begin
                mul_req <= '{start: 1'b1, a: operand_a, b: WORD_BITS'(1)};
                state   <= S_LAST;
              end
              ACT_TO_MONT: begin
                state <= S_MOD;
              end
              ACT_POW: begin
                x       <= operand_a;
                e       <= exponent;
                mul_req <= '{start: 1'b1, a: r2_mod, b: WORD_BITS'(1)};
                state   <= S_ONE;
              end
              default: begin
                x       <= operand_b;
                saved_a <= operand_a;
                e       <= EXP_BITS'(modulus - WORD_BITS'(2));
                mul_req <= '{start: 1'b1, a: r2_mod, b: WORD_BITS'(1)};
                state   <= S_ONE;
              end
            endcase
          end
        end
        S_MOD: begin
          if (red_done) begin
            mul_req <= '{start: 1'b1, a: red_res, b: r2_mod};
            state   <= S_LAST;
          end
        end
        S_ONE, S_PMUL, S_SQR: begin
          if (mul_rsp.done) begin
            if (state == S_SQR) begin
              x <= mul_rsp.p;
              e <= e >> 1;
            end else begin
              acc <= mul_rsp.p;
            end
            if (fin_now) begin
              if (act == ACT_DIV) begin
                mul_req <= '{start: 1'b1, a: saved_a, b: fin_val};
                state   <= S_LAST;
              end else begin
                result <= fin_val;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end else if (state == S_PMUL) begin
              mul_req <= '{start: 1'b1, a: x, b: x};
              state   <= S_SQR;
            end else if (d_e[0]) begin
              mul_req <= '{start: 1'b1, a: d_acc, b: d_x};
              state   <= S_PMUL;
            end else begin
              mul_req <= '{start: 1'b1, a: d_x, b: d_x};
              state   <= S_SQR;
            end
          end
        end
        S_LAST: begin
          if (mul_rsp.done) begin
            result <= mul_rsp.p;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mma_mod_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .value   (plain_value),
    .modulus (modulus),
    .done    (red_done),
    .residue (red_res)
  );

  mma_mont_mul u_mont_mul (
    .clk         (clk),
    .rst         (rst),
    .req         (mul_req),
    .modulus     (modulus),
    .neg_inverse (neg_inverse),
    .rsp         (mul_rsp)
  );

`ifndef ASSERT_OFF
  a_done_when_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result transfer while an operation is still running");

  a_mul_done_expected : assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_ONE || state == S_PMUL || state == S_SQR ||
                      state == S_LAST))
    else $error("multiplier result arrived in a state that does not wait for it");

  a_residue_expected : assert property (@(posedge clk) disable iff (rst)
    red_done |-> state == S_MOD)
    else $error("residue arrived outside the to_mont step");

  a_simple_one_cycle : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_ADD || action == ACT_SUB ||
                        action == ACT_NEG)) |=> done)
    else $error("add, subtract or negate did not finish in one cycle");
`endif

endmodule : montgomery_modular_alu
`default_nettype wire

### rtl/mma_mont_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Montgomery multiplier
// Computes a * b * 2^-32 mod N on one 32 x 32 multiplier that forms the
// product, the reduction quotient and the quotient times N in turn.
// ----------------------------------------------------------------------------
module mma_mont_mul
  import mma_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  input  wire word_t    modulus,
  input  wire word_t    neg_inverse,
  output mul_rsp_t      rsp
);

  typedef enum logic [4:0] {
    MP_IDLE = 5'b00001,
    MP_LOW  = 5'b00010,
    MP_QUOT = 5'b00100,
    MP_SUM  = 5'b01000,
    MP_FIX  = 5'b10000
  } phase_t;

  phase_t         phase;
  dword_t         t;
  word_t          m;
  dword_t         q;
  logic [WORD_BITS:0]   s;
  word_t          mul_x;
  word_t          mul_y;
  dword_t         prod;
  logic [2*WORD_BITS:0] sum_full;
  logic [WORD_BITS:0]   s_sub;
  logic                 s_ge;

  always_comb begin
    case (phase)
      MP_LOW: begin
        mul_x = t[WORD_BITS-1:0];
        mul_y = neg_inverse;
      end
      MP_QUOT: begin
        mul_x = m;
        mul_y = modulus;
      end
      default: begin
        mul_x = req.a;
        mul_y = req.b;
      end
    endcase
  end

  assign prod     = dword_t'(mul_x) * dword_t'(mul_y);
  assign sum_full = {1'b0, t} + {1'b0, q};
  assign s_ge     = s >= {1'b0, modulus};
  assign s_sub    = s - {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= MP_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (phase)
        MP_IDLE: begin
          if (req.start) begin
            t     <= prod;
            phase <= MP_LOW;
          end
        end
        MP_LOW: begin
          m     <= prod[WORD_BITS-1:0];
          phase <= MP_QUOT;
        end
        MP_QUOT: begin
          q     <= prod;
          phase <= MP_SUM;
        end
        MP_SUM: begin
          s     <= sum_full[2*WORD_BITS:WORD_BITS];
          phase <= MP_FIX;
        end
        MP_FIX: begin
          rsp.p    <= s_ge ? s_sub[WORD_BITS-1:0] : s[WORD_BITS-1:0];
          rsp.done <= 1'b1;
          phase    <= MP_IDLE;
        end
        default: begin
          phase <= MP_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_start_when_idle : assert property (@(posedge clk) disable iff (rst)
    req.start |-> phase == MP_IDLE)
    else $error("multiplier started while a product is in progress");
`endif

endmodule : mma_mont_mul
`default_nettype wire

### rtl/mma_mod_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed residue unit
// Reduces a signed 64-bit value to its true residue in [0, N) by restoring
// remainder steps, one dividend bit per cycle, then fixes the sign.
// ----------------------------------------------------------------------------
module mma_mod_reduce
  import mma_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [PLAIN_BITS-1:0] value,
  input  wire word_t                 modulus,
  output logic                       done,
  output word_t                      residue
);

  localparam int unsigned CNT_BITS = $clog2(PLAIN_BITS);

  typedef enum logic [2:0] {
    RD_IDLE = 3'b001,
    RD_RUN  = 3'b010,
    RD_FIX  = 3'b100
  } rd_state_t;

  rd_state_t             state;
  logic                  neg;
  logic [PLAIN_BITS-1:0] mag;
  word_t                 rem;
  logic [CNT_BITS-1:0]   cnt;
  logic [WORD_BITS:0]    shifted;
  logic [WORD_BITS:0]    shifted_sub;

  assign shifted     = {rem, mag[PLAIN_BITS-1]};
  assign shifted_sub = shifted - {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        RD_IDLE: begin
          if (start) begin
            neg   <= value[PLAIN_BITS-1];
            mag   <= value[PLAIN_BITS-1] ? (PLAIN_BITS'(0) - value) : value;
            rem   <= '0;
            cnt   <= CNT_BITS'(PLAIN_BITS - 1);
            state <= RD_RUN;
          end
        end
        RD_RUN: begin
          rem <= (shifted >= {1'b0, modulus}) ? shifted_sub[WORD_BITS-1:0]
                                              : shifted[WORD_BITS-1:0];
          mag <= {mag[PLAIN_BITS-2:0], 1'b0};
          cnt <= cnt - CNT_BITS'(1);
          if (cnt == '0) begin
            state <= RD_FIX;
          end
        end
        RD_FIX: begin
          if (modulus == '0) begin
            residue <= '0;
          end else if (neg && rem != '0) begin
            residue <= modulus - rem;
          end else begin
            residue <= rem;
          end
          done  <= 1'b1;
          state <= RD_IDLE;
        end
        default: begin
          state <= RD_IDLE;
        end
      endcase
    end
  end

endmodule : mma_mod_reduce
`default_nettype wire
